// ===== rtl/bracket_balance_checker_defines.svh =====
// ----------------------------------------------------------------------------
// Bracket balance checker assertion macros
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bracket_balance_checker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bracket_balance_checker: next-cycle check failed");

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, lexer mode codes, event codes and character constants for the
// bracket balance checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] ev_type;
   typedef logic [1:0] kind_type;
   typedef logic [2:0] mode_type;
   typedef logic [6:0] depth_type;

   localparam mode_type MODE_NORMAL     = 3'd0;
   localparam mode_type MODE_SLASH      = 3'd1;
   localparam mode_type MODE_LINE       = 3'd2;
   localparam mode_type MODE_BLOCK      = 3'd3;
   localparam mode_type MODE_BLOCK_STAR = 3'd4;
   localparam mode_type MODE_STRING     = 3'd5;

   localparam ev_type EV_NONE     = 3'd0;
   localparam ev_type EV_PUSH     = 3'd1;
   localparam ev_type EV_MATCH    = 3'd2;
   localparam ev_type EV_EMPTY    = 3'd3;
   localparam ev_type EV_MISMATCH = 3'd4;
   localparam ev_type EV_OVERFLOW = 3'd5;

   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;

   localparam byte_type CHAR_LPAREN  = 8'h28;
   localparam byte_type CHAR_RPAREN  = 8'h29;
   localparam byte_type CHAR_LBRACK  = 8'h5B;
   localparam byte_type CHAR_RBRACK  = 8'h5D;
   localparam byte_type CHAR_LBRACE  = 8'h7B;
   localparam byte_type CHAR_RBRACE  = 8'h7D;
   localparam byte_type CHAR_SLASH   = 8'h2F;
   localparam byte_type CHAR_STAR    = 8'h2A;
   localparam byte_type CHAR_QUOTE   = 8'h22;
   localparam byte_type CHAR_NEWLINE = 8'h0A;

endpackage

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Byte-stream bracket balance checker that skips comments and strings.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the text on the req_ channel, one byte per transaction, with
//   req_end_of_text high on the final byte. Every accepted byte produces
//   exactly one transaction on the rsp_ channel: the bracket event, the kind
//   seen, the kind popped, the depth after the byte and, on the last byte,
//   whether openers remain unmatched.
//   An accepted byte is registered and presented on rsp_ in the following
//   cycle. Throughput is one byte per cycle while the receiver keeps up,
//   as the lexer mode, stack pointer and cached top of stack update together.
//   The opener stack sits in a memory with a registered read port that
//   always fetches the entry below the top, so a pop never waits.
//   A stalled receiver holds the result register; req_ready stays high as
//   long as that register is empty or being drained in the same cycle.
//   Reset (synchronous, active high) clears the mode, stack pointer and
//   output valid. The last byte of a text returns the mode and stack
//   pointer to that state. The stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bracket_balance_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  bbc_pkg::byte_type   req_text_byte,
   input  wire                 req_end_of_text,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output bbc_pkg::ev_type     rsp_event_res,
   output bbc_pkg::kind_type   rsp_bracket_kind,
   output bbc_pkg::kind_type   rsp_popped_kind,
   output bbc_pkg::depth_type  rsp_nesting_depth,
   output logic                rsp_unmatched_open,
   output logic                rsp_done_res
);

   import bbc_pkg::*;

   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SpW   = $clog2(STACK_DEPTH + 1);

   // Stack storage and pointer state
   kind_type            stack_mem [STACK_DEPTH];
   kind_type            below_ff;
   kind_type            top_ff;
   kind_type            top_in;
   logic [SpW-1:0]      sp_ff;
   logic [SpW-1:0]      sp_in;
   logic [SpW-1:0]      sp_after;
   logic [SpW-1:0]      sp_less2;
   logic [AddrW-1:0]    rd_addr;
   mode_type            mode_ff;
   mode_type            mode_in;

   // Result register
   logic                rsp_valid_ff;
   ev_type              ev_ff;
   kind_type            kind_ff;
   kind_type            popped_ff;
   depth_type           depth_ff;
   logic                unmatched_ff;
   logic                done_ff;

   // Per-byte decode
   logic                fire;
   logic                run_normal;
   logic                do_push;
   logic                do_pop;
   mode_type            mode_step;
   ev_type              ev_in;
   kind_type            kind_in;
   kind_type            popped_in;
   logic                unmatched_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   always_comb begin
      mode_step  = mode_ff;
      run_normal = 1'b0;
      case (mode_ff)
         MODE_SLASH: begin
            if (req_text_byte == CHAR_SLASH) begin
               mode_step = MODE_LINE;
            end else if (req_text_byte == CHAR_STAR) begin
               mode_step = MODE_BLOCK;
            end else begin
               // lone slash: drop it and treat this byte as text
               mode_step  = MODE_NORMAL;
               run_normal = 1'b1;
            end
         end
         MODE_LINE: begin
            if (req_text_byte == CHAR_NEWLINE) begin
               mode_step = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (req_text_byte == CHAR_STAR) begin
               mode_step = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (req_text_byte == CHAR_SLASH) begin
               mode_step = MODE_NORMAL;
            end else if (req_text_byte != CHAR_STAR) begin
               mode_step = MODE_BLOCK;
            end
         end
         MODE_STRING: begin
            if (req_text_byte == CHAR_QUOTE) begin
               mode_step = MODE_NORMAL;
            end
         end
         default: begin
            mode_step  = MODE_NORMAL;
            run_normal = 1'b1;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_step;
      ev_in     = EV_NONE;
      kind_in   = KIND_ROUND;
      popped_in = KIND_ROUND;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      if (run_normal) begin
         if (req_text_byte == CHAR_SLASH) begin
            mode_in = MODE_SLASH;
         end else if (req_text_byte == CHAR_QUOTE) begin
            mode_in = MODE_STRING;
         end else if (req_text_byte inside {CHAR_LPAREN, CHAR_LBRACK, CHAR_LBRACE}) begin
            case (req_text_byte)
               CHAR_LBRACK: kind_in = KIND_SQUARE;
               CHAR_LBRACE: kind_in = KIND_CURLY;
               default:     kind_in = KIND_ROUND;
            endcase
            if (sp_ff >= SpW'(STACK_DEPTH)) begin
               ev_in = EV_OVERFLOW;
            end else begin
               ev_in   = EV_PUSH;
               do_push = 1'b1;
            end
         end else if (req_text_byte inside {CHAR_RPAREN, CHAR_RBRACK, CHAR_RBRACE}) begin
            case (req_text_byte)
               CHAR_RBRACK: kind_in = KIND_SQUARE;
               CHAR_RBRACE: kind_in = KIND_CURLY;
               default:     kind_in = KIND_ROUND;
            endcase
            if (sp_ff == '0) begin
               ev_in = EV_EMPTY;
            end else begin
               do_pop    = 1'b1;
               popped_in = top_ff;
               ev_in     = (top_ff == kind_in) ? EV_MATCH : EV_MISMATCH;
            end
         end
      end
   end

   always_comb begin
      sp_after = sp_ff;
      top_in   = top_ff;
      if (do_push) begin
         sp_after = sp_ff + SpW'(1);
         top_in   = kind_in;
      end else if (do_pop) begin
         sp_after = sp_ff - SpW'(1);
         top_in   = below_ff;
      end
      unmatched_in = req_end_of_text && (sp_after != '0);
      sp_in        = req_end_of_text ? '0 : sp_after;
   end

   // Fetch the entry below the new top so a pop next cycle finds it ready
   assign sp_less2 = (fire ? sp_in : sp_ff) - SpW'(2);
   assign rd_addr  = sp_less2[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (fire && do_push) begin
         stack_mem[sp_ff[AddrW-1:0]] <= kind_in;
      end
      below_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            mode_ff <= req_end_of_text ? MODE_NORMAL : mode_in;
            sp_ff   <= sp_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: load on every accepted transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (fire) begin
         top_ff       <= top_in;
         ev_ff        <= ev_in;
         kind_ff      <= kind_in;
         popped_ff    <= popped_in;
         depth_ff     <= depth_type'(sp_after);
         unmatched_ff <= unmatched_in;
         done_ff      <= req_end_of_text;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = ev_ff;
   assign rsp_bracket_kind   = kind_ff;
   assign rsp_popped_kind    = popped_ff;
   assign rsp_nesting_depth  = depth_ff;
   assign rsp_unmatched_open = unmatched_ff;
   assign rsp_done_res       = done_ff;

   `BBC_ASSERT_SAME(a_sp_bound, clock, reset, 1'b1, sp_ff <= SpW'(STACK_DEPTH))
   `BBC_ASSERT_NEXT(a_end_resets, clock, reset, fire && req_end_of_text,
                    sp_ff == '0 && mode_ff == MODE_NORMAL)
   `BBC_ASSERT_NEXT(a_push_top, clock, reset, fire && do_push && !req_end_of_text,
                    top_ff == $past(kind_in) && sp_ff == $past(sp_ff) + SpW'(1))
   `BBC_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_ready)

endmodule

`default_nettype wire
